[src/slu_pkg.sv]
package slu_pkg;

	localparam int WordBits  = 60;
	localparam int CoeffBits = 48;
	localparam int AuxBits   = 18;
	localparam int CountBits = 8;
	localparam int ExpInBits = 18;
	localparam int OpBits    = 3;
	localparam int ShBits    = 6;

	typedef logic [WordBits-1:0]  word_t;
	typedef logic [CoeffBits-1:0] coeff_t;
	typedef logic [AuxBits-1:0]   aux_t;
	typedef logic [OpBits-1:0]    opcode_t;
	typedef logic [ShBits-1:0]    shamt_t;

	localparam opcode_t OP_ROTL   = 3'd0;
	localparam opcode_t OP_SRA    = 3'd1;
	localparam opcode_t OP_PACK   = 3'd2;
	localparam opcode_t OP_UNPACK = 3'd3;
	localparam opcode_t OP_NORM   = 3'd4;
	localparam opcode_t OP_RNORM  = 3'd5;
	localparam opcode_t OP_MASK   = 3'd6;
	localparam opcode_t OP_UNDEF  = 3'd7;

	localparam logic [10:0] EXP_BIAS    = 11'o2000;
	localparam logic [9:0]  EXP_SPECIAL = 10'o1777;
	localparam shamt_t      WORD_SHIFT_MAX  = 6'd60;
	localparam shamt_t      COEFF_SHIFT_MAX = 6'd48;

	typedef struct packed {
		opcode_t     op;
		word_t       operand;
		logic        sign;
		coeff_t      coeff;
		logic [11:0] expo;
		shamt_t      shamt;
		word_t       simple_res;
		aux_t        simple_aux;
	} s1_t;

	typedef struct packed {
		opcode_t     op;
		word_t       operand;
		logic        sign;
		coeff_t      coeff;
		logic [11:0] expo;
		shamt_t      lz;
		word_t       res;
		aux_t        aux;
	} s2_t;

	typedef struct packed {
		opcode_t op;
		word_t   res;
		aux_t    aux;
	} s3_t;

endpackage

[src/slu_if.sv]
interface slu_req_if;
	import slu_pkg::*;
	logic    valid;
	logic    ready;
	opcode_t opcode;
	word_t   operand;
	logic [CountBits-1:0] count;
	logic [ExpInBits-1:0] exponent_in;

	modport source(output valid, opcode, operand, count, exponent_in, input ready);
	modport sink(input valid, opcode, operand, count, exponent_in, output ready);
endinterface

interface slu_rsp_if;
	import slu_pkg::*;
	logic  valid;
	logic  ready;
	word_t result;
	aux_t  aux_out;

	modport source(output valid, result, aux_out, input ready);
	modport sink(input valid, result, aux_out, output ready);
endinterface

[src/sixty_bit_shift_unit_core.sv]
// Shift unit of a 60-bit ones'-complement machine.
// Requests arrive on req (valid/ready): opcode, operand, count, exponent_in.
// Results leave on rsp (valid/ready): result and aux_out, one per request,
// in request order.
// Opcodes: rotate left, shift right arithmetic, pack, unpack, normalize,
// round normalize, mask; opcode 7 returns zero.
// Pipeline: a request passes through three registered stages (decode, barrel shift
// and leading-zero count, normalize); rsp.valid rises once the normalize stage
// register holds its result, which can then be taken when rsp.ready is high.
// Throughput: one request per cycle unless a stall holds req.ready low; each stage holds one request.
// Stall: when rsp.ready is low the stages fill up behind the output register,
// and req.ready drops once all three hold a request; nothing is lost.
// Reset: arst_n empties the pipeline at once; req.ready is high after reset.
module sixty_bit_shift_unit_core (
	input  logic           clk,
	input  logic           arst_n,
	slu_req_if.sink        req,
	slu_rsp_if.source      rsp
);
	import slu_pkg::*;

	s1_t  d_c;
	s2_t  sh_c;
	s3_t  nm_c;
	s1_t  st_s1;
	s2_t  st_s2;
	s3_t  st_s3;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic en1;
	logic en2;
	logic en3;

	slu_decode u_decode (
		.opcode      (req.opcode),
		.operand     (req.operand),
		.count       (req.count),
		.exponent_in (req.exponent_in),
		.d           (d_c)
	);

	slu_shift u_shift (
		.a (st_s1),
		.b (sh_c)
	);

	slu_norm u_norm (
		.a (st_s2),
		.b (nm_c)
	);

	assign en3 = !v_s3 || rsp.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req.valid) begin
			st_s1 <= d_c;
		end
		if (en2 && v_s1) begin
			st_s2 <= sh_c;
		end
		if (en3 && v_s2) begin
			st_s3 <= nm_c;
		end
	end

	assign rsp.valid   = v_s3;
	assign rsp.result  = st_s3.res;
	assign rsp.aux_out = st_s3.aux;

`ifndef ASSERT_OFF
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (v_s1 && v_s2 && v_s3 && !rsp.ready))
		else $error("request refused while pipeline has room");

	a_norm_aux: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (st_s3.op == OP_NORM || st_s3.op == OP_RNORM))
		|-> (rsp.aux_out <= aux_t'(COEFF_SHIFT_MAX)))
		else $error("normalize shift count out of range");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && st_s3.op == OP_UNDEF) |-> (rsp.result == '0 && rsp.aux_out == '0))
		else $error("undefined opcode gave nonzero result");
`endif

endmodule

[src/slu_decode.sv]
module slu_decode (
	input  slu_pkg::opcode_t               opcode,
	input  slu_pkg::word_t                 operand,
	input  logic [slu_pkg::CountBits-1:0]  count,
	input  logic [slu_pkg::ExpInBits-1:0]  exponent_in,
	output slu_pkg::s1_t                   d
);
	import slu_pkg::*;

	logic   sign;
	word_t  w;
	shamt_t n6;
	shamt_t rot_n;
	shamt_t sra_n;
	shamt_t mask_n;
	logic [10:0] pack_e;

	always_comb begin
		sign   = operand[WordBits-1];
		w      = operand ^ {WordBits{sign}};
		n6     = count[ShBits-1:0];
		rot_n  = (n6 >= WORD_SHIFT_MAX) ? n6 - WORD_SHIFT_MAX : n6;
		sra_n  = (n6 > WORD_SHIFT_MAX) ? WORD_SHIFT_MAX : n6;
		mask_n = (count > {2'b00, WORD_SHIFT_MAX}) ? WORD_SHIFT_MAX : count[ShBits-1:0];
		pack_e = exponent_in[10:0] ^ EXP_BIAS;

		d.op      = opcode;
		d.operand = operand;
		d.sign    = sign;
		d.coeff   = w[CoeffBits-1:0];
		d.expo    = w[WordBits-1:CoeffBits];

		case (opcode)
			OP_ROTL: d.shamt = rot_n;
			OP_SRA:  d.shamt = sra_n;
			OP_MASK: d.shamt = mask_n;
			default: d.shamt = '0;
		endcase

		case (opcode)
			OP_PACK: begin
				d.simple_res = {1'b0, pack_e, w[CoeffBits-1:0]} ^ {WordBits{sign}};
				d.simple_aux = '0;
			end
			OP_UNPACK: begin
				d.simple_res = {12'b0, w[CoeffBits-1:0]} ^ {WordBits{sign}};
				d.simple_aux = {6'b0, w[WordBits-1:CoeffBits]} - {7'b0, EXP_BIAS};
			end
			default: begin
				d.simple_res = '0;
				d.simple_aux = '0;
			end
		endcase
	end

endmodule

[src/slu_shift.sv]
module slu_shift (
	input  slu_pkg::s1_t a,
	output slu_pkg::s2_t b
);
	import slu_pkg::*;

	logic [2*WordBits-1:0] rot_w;
	word_t  sra_w;
	word_t  mask_w;
	shamt_t lz;

	always_comb begin
		rot_w  = {a.operand, a.operand} << a.shamt;
		sra_w  = word_t'($signed(a.operand) >>> a.shamt);
		mask_w = ~({WordBits{1'b1}} >> a.shamt);

		lz = COEFF_SHIFT_MAX;
		for (int i = 0; i < CoeffBits; i++) begin
			if (a.coeff[i]) begin
				lz = ShBits'(CoeffBits - 1 - i);
			end
		end

		b.op      = a.op;
		b.operand = a.operand;
		b.sign    = a.sign;
		b.coeff   = a.coeff;
		b.expo    = a.expo;
		b.lz      = lz;
		b.aux     = a.simple_aux;

		case (a.op)
			OP_ROTL: b.res = rot_w[2*WordBits-1:WordBits];
			OP_SRA:  b.res = sra_w;
			OP_MASK: b.res = mask_w;
			default: b.res = a.simple_res;
		endcase
	end

endmodule

[src/slu_norm.sv]
module slu_norm (
	input  slu_pkg::s2_t a,
	output slu_pkg::s3_t b
);
	import slu_pkg::*;

	logic          special;
	logic          rnd;
	coeff_t        shifted;
	logic [CoeffBits:0] rb;
	coeff_t        ncoeff;
	logic signed [13:0] e0;
	logic signed [13:0] e1;
	logic signed [13:0] e2;
	logic signed [13:0] ex;
	logic signed [13:0] bias;
	word_t         norm_res;

	always_comb begin
		special = (a.expo[9:0] == EXP_SPECIAL);
		rnd     = (a.op == OP_RNORM);
		shifted = a.coeff << a.lz;
		rb      = {{CoeffBits{1'b0}}, 1'b1} << a.lz;
		ncoeff  = rnd ? (shifted | rb[CoeffBits:1]) : shifted;

		bias = $signed({3'b000, EXP_BIAS});
		e0   = $signed({2'b00, a.expo}) - bias;
		e1   = (e0 < 14'sd0) ? e0 + 14'sd1 : e0;
		e2   = e1 - $signed({8'b0, a.lz});
		ex   = e2 + bias - ((e2 < 14'sd0) ? 14'sd1 : 14'sd0);

		if (special) begin
			norm_res = a.operand;
		end else if (!rnd && a.coeff == '0) begin
			norm_res = '0;
		end else if (ex < 14'sd0) begin
			norm_res = '0;
		end else begin
			norm_res = {1'b0, ex[10:0], ncoeff} ^ {WordBits{a.sign}};
		end

		b.op = a.op;
		case (a.op)
			OP_NORM, OP_RNORM: begin
				b.res = norm_res;
				b.aux = special ? '0 : {12'b0, a.lz};
			end
			default: begin
				b.res = a.res;
				b.aux = a.aux;
			end
		endcase
	end

endmodule

[tb/sv/shift_unit_monitor.sv]
module shift_unit_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  slu_pkg::opcode_t              opcode,
	input  slu_pkg::word_t                operand,
	input  logic [slu_pkg::CountBits-1:0] count,
	input  logic [slu_pkg::ExpInBits-1:0] exponent_in,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  slu_pkg::word_t                result,
	input  slu_pkg::aux_t                 aux_out,
	output int                            mismatches,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import slu_pkg::*;

	typedef struct packed {
		opcode_t op;
		word_t   word;
		aux_t    aux;
	} shift_outcome_t;

	shift_outcome_t predicted_outcomes[$];

	function automatic word_t top_mask(int n);
		if (n > WordBits) begin
			n = WordBits;
		end
		return ~({WordBits{1'b1}} >> n);
	endfunction

	function automatic shift_outcome_t predict_shift(opcode_t op, word_t x,
			logic [CountBits-1:0] cnt, logic [ExpInBits-1:0] ein);
		shift_outcome_t o;
		word_t sign_mask;
		word_t w;
		logic [CoeffBits-1:0] frac;
		int n;
		int lz;
		int ex;
		int e;
		logic [10:0] packed_exp;
		sign_mask = {WordBits{x[WordBits-1]}};
		w = x ^ sign_mask;
		o.op = op;
		o.word = '0;
		o.aux = '0;
		case (op)
			OP_ROTL: begin
				n = int'(cnt[5:0]);
				if (n >= WordBits) begin
					n -= WordBits;
				end
				o.word = (n == 0) ? x : ((x << n) | (x >> (WordBits - n)));
			end
			OP_SRA: begin
				n = int'(cnt[5:0]);
				if (n > WordBits) begin
					n = WordBits;
				end
				o.word = x >> n;
				if (x[WordBits-1]) begin
					o.word |= top_mask(n);
				end
			end
			OP_PACK: begin
				packed_exp = ein[10:0] ^ EXP_BIAS;
				o.word = {1'b0, packed_exp, w[CoeffBits-1:0]} ^ sign_mask;
			end
			OP_UNPACK: begin
				o.aux = {6'd0, w[59:48]} - 18'd1024;
				o.word = {12'd0, w[CoeffBits-1:0]} ^ sign_mask;
			end
			OP_NORM, OP_RNORM: begin
				frac = w[CoeffBits-1:0];
				ex = int'({20'd0, w[59:48]});
				if (w[57:48] == EXP_SPECIAL) begin
					o.word = x;
				end else if (op == OP_NORM && frac == '0) begin
					o.aux = aux_t'(CoeffBits);
				end else begin
					lz = 0;
					while (lz < CoeffBits && frac[CoeffBits-1-lz] == 1'b0) begin
						lz++;
					end
					frac = (lz >= CoeffBits) ? '0 : (frac << lz);
					if (op == OP_RNORM && lz > 0) begin
						frac[lz-1] = 1'b1;
					end
					e = ex - 1024;
					if (e < 0) begin
						e += 1;
					end
					e -= lz;
					ex = e + 1024 - ((e < 0) ? 1 : 0);
					o.aux = aux_t'(lz);
					if (ex >= 0) begin
						packed_exp = ex[10:0];
						o.word = {1'b0, packed_exp, frac} ^ sign_mask;
					end
				end
			end
			OP_MASK: o.word = top_mask(int'(cnt));
			default: ;
		endcase
		return o;
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	always @(posedge clk) begin : watch
		shift_outcome_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predicted_outcomes.push_back(predict_shift(opcode, operand, count, exponent_in));
			end
			if (rsp_valid && rsp_ready) begin
				if (predicted_outcomes.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h aux %h", result, aux_out));
				end else begin
					want = predicted_outcomes.pop_front();
					if (want.word !== result || want.aux !== aux_out) begin
						flag_mismatch($sformatf(
							"op %0d expected result %h aux %h, got result %h aux %h",
							want.op, want.word, want.aux, result, aux_out));
					end
				end
			end
			outstanding = predicted_outcomes.size();
		end else begin
			mismatches = 0;
			outstanding = 0;
		end
	end
endmodule

[tb/sv/sixty_bit_shift_unit_core_test.sv]
module sixty_bit_shift_unit_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import slu_pkg::*;

	localparam int CycleLimit = 100000;
	localparam int ItemsPerPhase = 275;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   cycle_count = 0;
	int   mismatch_total;
	int   pending_total;
	int   phase_idle[4] = '{0, 69, 0, 24};
	int   phase_stall[4] = '{0, 0, 69, 24};

	slu_req_if req_ch();
	slu_rsp_if rsp_ch();

	sixty_bit_shift_unit_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	shift_unit_monitor mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.opcode      (req_ch.opcode),
		.operand     (req_ch.operand),
		.count       (req_ch.count),
		.exponent_in (req_ch.exponent_in),
		.rsp_valid   (rsp_ch.valid),
		.rsp_ready   (rsp_ch.ready),
		.result      (rsp_ch.result),
		.aux_out     (rsp_ch.aux_out),
		.mismatches  (mismatch_total),
		.outstanding (pending_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAIL sixty_bit_shift_unit_core");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_request(opcode_t op, word_t x, logic [CountBits-1:0] cnt,
			logic [ExpInBits-1:0] ein);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.operand <= x;
		req_ch.count <= cnt;
		req_ch.exponent_in <= ein;
		// hold the request until accepted
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_total != 0);
	endtask

	task automatic issue_random_request();
		opcode_t op;
		word_t x;
		logic [63:0] raw;
		logic [CoeffBits-1:0] frac;
		logic [10:0] ex;
		int lz;
		int pick;
		pick = $urandom_range(99);
		op = (pick < 4) ? OP_UNDEF : opcode_t'(pick % 7);
		raw = {$urandom, $urandom};
		x = raw[WordBits-1:0];
		if ((op == OP_UNPACK || op == OP_NORM || op == OP_RNORM) && $urandom_range(9) < 7) begin
			case ($urandom_range(3))
				0: ex = 11'($urandom);
				1: ex = 11'($urandom_range(1034, 1014));
				2: ex = 11'($urandom_range(64));
				default: ex = {1'($urandom), EXP_SPECIAL};
			endcase
			lz = ($urandom_range(3) == 0) ? 0 : $urandom_range(CoeffBits);
			frac = (x[CoeffBits-1:0] | 48'h8000_0000_0000) >> lz;
			x = {1'b0, ex, frac};
			if ($urandom_range(1) == 1) begin
				x = ~x;
			end
		end else if ($urandom_range(9) == 0) begin
			x = x >> $urandom_range(WordBits);
		end
		send_request(op, x, 8'($urandom), 18'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ROTL;
		req_ch.operand = '0;
		req_ch.count = '0;
		req_ch.exponent_in = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(OP_ROTL, 60'h800_0000_0000_0001, 8'd0, 18'd0);
		send_request(OP_ROTL, 60'h800_0000_0000_0001, 8'd1, 18'd0);
		send_request(OP_ROTL, 60'h123_4567_89AB_CDEF, 8'd59, 18'd0);
		send_request(OP_ROTL, 60'h123_4567_89AB_CDEF, 8'd60, 18'd0);
		send_request(OP_ROTL, 60'hFED_CBA9_8765_4321, 8'd255, 18'd0);
		send_request(OP_SRA, 60'h800_0000_0000_0000, 8'd0, 18'd0);
		send_request(OP_SRA, 60'h8F0_0000_0000_0000, 8'd60, 18'd0);
		send_request(OP_SRA, 60'h8F0_0000_0000_0000, 8'd127, 18'd0);
		send_request(OP_SRA, 60'h7FF_FFFF_FFFF_FFFF, 8'd30, 18'd0);
		send_request(OP_PACK, 60'h000_FFFF_FFFF_FFFF, 8'd0, 18'd0);
		send_request(OP_PACK, 60'hFFF_0000_0000_0000, 8'd0, 18'h3FFFF);
		send_request(OP_PACK, 60'h000_1234_5678_9ABC, 8'd0, 18'o1777);
		send_request(OP_UNPACK, 60'h000_0000_0000_0000, 8'd0, 18'd0);
		send_request(OP_UNPACK, 60'h7FF_FFFF_FFFF_FFFF, 8'd0, 18'd0);
		send_request(OP_UNPACK, 60'hBFF_0000_0000_0123, 8'd0, 18'd0);
		send_request(OP_NORM, 60'h3FF_0000_0000_0001, 8'd0, 18'd0);
		send_request(OP_NORM, 60'h400_0000_0000_0000, 8'd0, 18'd0);
		send_request(OP_RNORM, 60'h400_0000_0000_0000, 8'd0, 18'd0);
		send_request(OP_NORM, 60'h000_0000_0000_0001, 8'd0, 18'd0);
		send_request(OP_NORM, 60'hBFF_FFFF_FFFE_FFFF, 8'd0, 18'd0);
		send_request(OP_NORM, 60'h400_8000_0000_0000, 8'd0, 18'd0);
		send_request(OP_RNORM, 60'h400_0000_0000_0F00, 8'd0, 18'd0);
		send_request(OP_MASK, 60'h0, 8'd0, 18'd0);
		send_request(OP_MASK, 60'h0, 8'd1, 18'd0);
		send_request(OP_MASK, 60'h0, 8'd60, 18'd0);
		send_request(OP_MASK, 60'h0, 8'd255, 18'd0);
		send_request(OP_UNDEF, 60'hFFF_FFFF_FFFF_FFFF, 8'd255, 18'h3FFFF);
		drain_results();

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			repeat (ItemsPerPhase) issue_random_request();
			// pause the sender until every result is back
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (mismatch_total == 0 && pending_total == 0) begin
			$display("PASS sixty_bit_shift_unit_core");
		end else begin
			$display("FAIL sixty_bit_shift_unit_core");
		end
		$finish;
	end
endmodule
